// File: rtl/core/rdeg_pkg.sv
// Shared types, constants and tables for the RMS downward expander gate.
`timescale 1ns / 1ps

package rdeg_pkg;

  localparam int DefChannelCount = 2;

  localparam int SAMPLE_W   = 24;
  localparam int GAIN_W     = 17;
  localparam int COEF_W     = 24;
  localparam int DB_W       = 16;
  localparam int SLOPE_W    = 16;
  localparam int ENV_W      = 48;
  localparam int SQ_W       = 47;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;
  localparam int MUL_W      = 33;
  localparam int PROD_W     = 2 * MUL_W;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 48;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ATTACK    = 2'd0,
    REG_RELEASE   = 2'd1,
    REG_THRESHOLD = 2'd2,
    REG_SLOPE     = 2'd3
  } cfg_reg_t;

  localparam logic [COEF_W-1:0]  ATTACK_RESET    = 24'd16742310;
  localparam logic [COEF_W-1:0]  RELEASE_RESET   = 24'd16773721;
  localparam logic [DB_W-1:0]    THRESHOLD_RESET = 16'hD800;
  localparam logic [SLOPE_W-1:0] SLOPE_RESET     = 16'd49152;

  localparam logic [SQ_W-1:0]    ENV_FULL        = 47'h4000_0000_0000;
  localparam logic [16:0]        DB_FLOOR        = 17'd25600;
  localparam logic signed [15:0] LVL_FLOOR       = -16'sd25600;
  localparam logic [17:0]        DB_PER_LOG2_Q16 = 18'd197283;
  localparam logic [21:0]        LOG2_10_20_Q24  = 22'd2786635;
  localparam logic [29:0]        LN2_Q30         = 30'd744261118;
  localparam logic [30:0]        ONE_Q30         = 31'h4000_0000;
  localparam logic [GAIN_W-1:0]  UNITY_GAIN      = 17'h10000;
  localparam logic [5:0]         TOP_BIT         = 6'd46;

  // 2^-(2^-(k+1)) in Q30 for fraction bits 15 down to 8
  function automatic logic [29:0] exp_step(input logic [2:0] k);
    logic [29:0] v;
    case (k)
      3'd0:    v = 30'd759250125;
      3'd1:    v = 30'd902905651;
      3'd2:    v = 30'd984625594;
      3'd3:    v = 30'd1028218693;
      3'd4:    v = 30'd1050733751;
      3'd5:    v = 30'd1062175491;
      3'd6:    v = 30'd1067942999;
      default: v = 30'd1070838486;
    endcase
    return v;
  endfunction

  typedef enum logic [4:0] {
    ST_IDLE, ST_SQUARE, ST_DIFF, ST_WLO, ST_WHI, ST_UPDATE, ST_NORM, ST_LOGSQ,
    ST_DB, ST_CMP, ST_GMUL, ST_EMUL, ST_EXP, ST_LNMUL, ST_LNAPPLY, ST_SHIFT,
    ST_OUTMUL
  } state_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_SQUARE, OP_DIFF, OP_WLO, OP_WHI, OP_UPDATE, OP_NORM,
    OP_LOGINIT, OP_LOGSQ, OP_DB, OP_FLOOR, OP_CMP, OP_GMUL, OP_GZERO, OP_EMUL,
    OP_EXP, OP_LNMUL, OP_LNAPPLY, OP_SHIFT, OP_OUTMUL
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [3:0] cnt;
  } cmd_t;

  typedef struct packed {
    logic v_top;
    logic env_zero;
    logic unity;
    logic at_floor;
    logic cut_big;
    logic out_free;
  } status_t;

endpackage

// File: rtl/core/rdeg_ctrl.sv
// Sequencer that steps one sample through the shared datapath.
`timescale 1ns / 1ps

module rdeg_ctrl import rdeg_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  status_t st,
  output cmd_t    cmd
);

  state_t     state, state_next;
  logic [3:0] cnt, cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd.op     = OP_NONE;
    cmd.cnt    = cnt;
    in_ready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op     = OP_LOAD;
          state_next = ST_SQUARE;
        end
      end
      ST_SQUARE: begin
        cmd.op = OP_SQUARE; state_next = ST_DIFF;
      end
      ST_DIFF: begin
        cmd.op = OP_DIFF; state_next = ST_WLO;
      end
      ST_WLO: begin
        cmd.op = OP_WLO; state_next = ST_WHI;
      end
      ST_WHI: begin
        cmd.op = OP_WHI; state_next = ST_UPDATE;
      end
      ST_UPDATE: begin
        cmd.op = OP_UPDATE; state_next = ST_NORM;
      end
      ST_NORM: begin
        if (st.env_zero) begin
          cmd.op     = OP_FLOOR;
          state_next = ST_CMP;
        end else if (st.v_top) begin
          cmd.op     = OP_LOGINIT;
          cnt_next   = '0;
          state_next = ST_LOGSQ;
        end else begin
          cmd.op = OP_NORM;
        end
      end
      ST_LOGSQ: begin
        cmd.op   = OP_LOGSQ;
        cnt_next = cnt + 4'd1;
        if (cnt == 4'd15) state_next = ST_DB;
      end
      ST_DB: begin
        cmd.op = OP_DB; state_next = ST_CMP;
      end
      ST_CMP: begin
        cmd.op = OP_CMP;
        state_next = (st.unity || st.at_floor) ? ST_OUTMUL : ST_GMUL;
      end
      ST_GMUL: begin
        cmd.op = OP_GMUL; state_next = ST_EMUL;
      end
      ST_EMUL: begin
        cnt_next = '0;
        if (st.cut_big) begin
          cmd.op     = OP_GZERO;
          state_next = ST_OUTMUL;
        end else begin
          cmd.op     = OP_EMUL;
          state_next = ST_EXP;
        end
      end
      ST_EXP: begin
        cmd.op   = OP_EXP;
        cnt_next = cnt + 4'd1;
        if (cnt == 4'd7) state_next = ST_LNMUL;
      end
      ST_LNMUL: begin
        cmd.op = OP_LNMUL; state_next = ST_LNAPPLY;
      end
      ST_LNAPPLY: begin
        cmd.op = OP_LNAPPLY; state_next = ST_SHIFT;
      end
      ST_SHIFT: begin
        cmd.op = OP_SHIFT; state_next = ST_OUTMUL;
      end
      ST_OUTMUL: begin
        if (st.out_free) begin
          cmd.op     = OP_OUTMUL;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

// File: rtl/core/rdeg_datapath.sv
// Envelope store, configuration registers, shared multiplier and output register.
`timescale 1ns / 1ps

module rdeg_datapath import rdeg_pkg::*; #(
  parameter int CHANNEL_COUNT = DefChannelCount
) (
  input  logic                         clk,
  input  logic                         rst,
  input  cmd_t                         cmd,
  output status_t                      st,
  input  logic                         cfg_write,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [CFG_DATA_W-1:0]        cfg_data,
  input  logic signed [SAMPLE_W-1:0]   in_sample,
  input  logic                         in_chan,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [SAMPLE_W-1:0]   out_sample,
  output logic                         out_chan,
  output logic [GAIN_W-1:0]            out_gain
);

  localparam int IDX_W = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;

  function automatic logic [IDX_W-1:0] idx_of(input logic ch);
    return (CHANNEL_COUNT == 1) ? '0 : IDX_W'(ch);
  endfunction

  logic [ENV_W-1:0] env_mem [CHANNEL_COUNT];

  logic [COEF_W-1:0]         attack, release_c;
  logic signed [DB_W-1:0]    thr;
  logic [SLOPE_W-1:0]        slope;

  logic signed [SAMPLE_W-1:0] sample;
  logic                       chan;
  logic [ENV_W-1:0]           env_cur, d, w;
  logic [SQ_W-1:0]            x, v;
  logic                       gt, env_zero;
  logic [COEF_W-1:0]          coef;
  logic [5:0]                 p;
  logic [30:0]                m, acc, lnf;
  logic [15:0]                frac, f;
  logic signed [15:0]         lvl;
  logic [16:0]                diff, g;
  logic [4:0]                 n;
  logic [GAIN_W-1:0]          gain;

  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] prod;

  logic [ENV_W-1:0]   env_new;
  logic [31:0]        sq;
  logic [21:0]        mag;
  logic [40:0]        dbsum;
  logic [16:0]        db;
  logic [32:0]        gsum;
  logic [37:0]        esum;
  logic [4:0]         sh;
  logic [31:0]        rnd;
  logic signed [41:0] ysum;
  logic signed [25:0] y;
  logic signed [SAMPLE_W-1:0] ysat;

  // operand select for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      OP_SQUARE:  begin mul_a = MUL_W'(sample);    mul_b = MUL_W'(sample);          end
      OP_WLO:     begin mul_a = MUL_W'(coef);      mul_b = MUL_W'(d[23:0]);         end
      OP_WHI:     begin mul_a = MUL_W'(coef);      mul_b = MUL_W'(d[47:24]);        end
      OP_LOGSQ:   begin mul_a = MUL_W'(m);         mul_b = MUL_W'(m);               end
      OP_DB:      begin mul_a = MUL_W'(mag);       mul_b = MUL_W'(DB_PER_LOG2_Q16); end
      OP_GMUL:    begin mul_a = MUL_W'(diff);      mul_b = MUL_W'(slope);           end
      OP_EMUL:    begin mul_a = MUL_W'(g[14:0]);   mul_b = MUL_W'(LOG2_10_20_Q24);  end
      OP_EXP:     begin mul_a = MUL_W'(acc);
                        mul_b = MUL_W'(exp_step(cmd.cnt[2:0]));                     end
      OP_LNMUL:   begin mul_a = MUL_W'(LN2_Q30);   mul_b = MUL_W'(f[7:0]);          end
      OP_LNAPPLY: begin mul_a = MUL_W'(acc);       mul_b = MUL_W'(lnf);             end
      OP_OUTMUL:  begin mul_a = MUL_W'(sample);    mul_b = MUL_W'(gain);            end
      default:    ;
    endcase
  end

  assign prod = mul_a * mul_b;

  always_comb begin
    env_new = gt ? ENV_W'(x) - w : ENV_W'(x) + w;
    sq      = prod[61:30];
    mag     = {6'(TOP_BIT - p), 16'd0} - {6'd0, frac};
    dbsum   = prod[40:0] + 41'h80_0000;
    db      = dbsum[40:24];
    gsum    = prod[32:0] + 33'h8000;
    esum    = prod[37:0] + 38'h8000;
    sh      = 5'd14 + n;
    rnd     = 32'(acc) + (32'd1 << (sh - 5'd1));
    ysum    = prod[41:0] + 42'sd32768;
    y       = 26'(ysum >>> 16);
    if (y > 26'sd8388607)       ysat = 24'sh7FFFFF;
    else if (y < -26'sd8388608) ysat = -24'sh800000;
    else                        ysat = y[SAMPLE_W-1:0];
  end

  assign st.v_top    = v[SQ_W-1];
  assign st.env_zero = env_zero;
  assign st.unity    = lvl >= thr;
  assign st.at_floor = lvl <= LVL_FLOOR;
  assign st.cut_big  = g >= DB_FLOOR;
  assign st.out_free = !out_valid || out_ready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      attack    <= ATTACK_RESET;
      release_c <= RELEASE_RESET;
      thr       <= THRESHOLD_RESET;
      slope     <= SLOPE_RESET;
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_ATTACK:    attack    <= cfg_data;
        REG_RELEASE:   release_c <= cfg_data;
        REG_THRESHOLD: thr       <= cfg_data[DB_W-1:0];
        REG_SLOPE:     slope     <= cfg_data[SLOPE_W-1:0];
        default:       ;
      endcase
    end
  end

  // envelope store and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNEL_COUNT; i++) env_mem[i] <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.op == OP_UPDATE) env_mem[idx_of(chan)] <= env_new;
      if (cmd.op == OP_OUTMUL)  out_valid <= 1'b1;
      else if (out_ready)       out_valid <= 1'b0;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        sample  <= in_sample;
        chan    <= in_chan;
        env_cur <= env_mem[idx_of(in_chan)];
      end
      OP_SQUARE: x <= prod[SQ_W-1:0];
      OP_DIFF: begin
        gt   <= ENV_W'(x) > env_cur;
        d    <= (ENV_W'(x) > env_cur) ? ENV_W'(x) - env_cur : env_cur - ENV_W'(x);
        coef <= (ENV_W'(x) > env_cur) ? attack : release_c;
      end
      OP_WLO: w <= ENV_W'(prod[47:24]);
      OP_WHI: w <= w + prod[ENV_W-1:0];
      OP_UPDATE: begin
        env_zero <= env_new == '0;
        v        <= (env_new > ENV_W'(ENV_FULL)) ? ENV_FULL : env_new[SQ_W-1:0];
        p        <= TOP_BIT;
      end
      OP_NORM: begin
        v <= v << 1;
        p <= p - 6'd1;
      end
      OP_LOGINIT: begin
        m    <= v[SQ_W-1:16];
        frac <= '0;
      end
      OP_LOGSQ: begin
        if (sq[31]) begin
          m    <= sq[31:1];
          frac <= {frac[14:0], 1'b1};
        end else begin
          m    <= sq[30:0];
          frac <= {frac[14:0], 1'b0};
        end
      end
      OP_DB:    lvl <= (db >= DB_FLOOR) ? LVL_FLOOR : $signed(16'd0 - db[15:0]);
      OP_FLOOR: lvl <= LVL_FLOOR;
      OP_CMP: begin
        gain <= (lvl >= thr) ? UNITY_GAIN : '0;
        diff <= 17'($signed({thr[15], thr}) - $signed({lvl[15], lvl}));
      end
      OP_GMUL:  g    <= gsum[32:16];
      OP_GZERO: gain <= '0;
      OP_EMUL: begin
        n   <= esum[36:32];
        f   <= esum[31:16];
        acc <= ONE_Q30;
      end
      OP_EXP:     if (f[4'd15 - cmd.cnt]) acc <= prod[60:30];
      OP_LNMUL:   lnf <= ONE_Q30 - 31'(prod[45:16]);
      OP_LNAPPLY: acc <= prod[60:30];
      OP_SHIFT:   gain <= GAIN_W'(rnd >> sh);
      OP_OUTMUL: begin
        out_sample <= ysat;
        out_chan   <= chan;
        out_gain   <= gain;
      end
      default: ;
    endcase
  end

endmodule

// File: rtl/core/rms_downward_expander_gate_core.sv
// Top level of the RMS downward expander gate: stream ports, sequencer and datapath.
`timescale 1ns / 1ps
// Sequence: a silent envelope skips the log, the leading-one search shifts one
//   bit a cycle, log2 takes 16 squaring passes and the gain exponent 13 more, all
//   on one shared 33x33 multiplier; the result then waits for the output register.
// Samples are handled one at a time; the next request is taken while the result
//   waits in the output register.
// Reset (rst, synchronous): clears every channel envelope, loads register defaults, drops valid.
module rms_downward_expander_gate_core import rdeg_pkg::*; #(
  parameter int CHANNEL_COUNT = DefChannelCount
) (
  input  logic                  clk,
  input  logic                  rst,
  // input request
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // [23:0] sample_in
  input  logic                  s_axis_tuser,  // [0] channel_in
  // result
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,  // [23:0] sample_out, [40:24] applied_gain
  output logic                  m_axis_tuser,  // [0] channel_out
  // register writes
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cmd_t    cmd;
  status_t st;

  logic signed [SAMPLE_W-1:0] out_sample;
  logic [GAIN_W-1:0]          out_gain;

  // Sequencer: holds one request at a time, advances through the arithmetic steps.
  rdeg_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .st       (st),
    .cmd      (cmd)
  );

  // Datapath: envelope store, registers, shared multiplier and output slot.
  rdeg_datapath #(
    .CHANNEL_COUNT (CHANNEL_COUNT)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .st         (st),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_sample  ($signed(s_axis_tdata[SAMPLE_W-1:0])),
    .in_chan    (s_axis_tuser),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_sample (out_sample),
    .out_chan   (m_axis_tuser),
    .out_gain   (out_gain)
  );

  // Pack the result; pad the upper bits with zeros.
  assign m_axis_tdata = {{(OUT_DATA_W - SAMPLE_W - GAIN_W){1'b0}}, out_gain, out_sample};

endmodule
